// ----- src/poly_least_squares_fit_core_assert.svh -----
// ----------------------------------------------------------------------------
// poly_least_squares_fit_core assertion macros
// shared property forms for the fitter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef POLY_LEAST_SQUARES_FIT_CORE_ASSERT_SVH
`define POLY_LEAST_SQUARES_FIT_CORE_ASSERT_SVH

// same-cycle implication
`define PLSF_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLSF_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/plsf_pkg.sv -----
// ----------------------------------------------------------------------------
// plsf_pkg
// types, constants and the solve program of the least-squares fitter
// ----------------------------------------------------------------------------
package plsf_pkg;

   localparam int CoordW = 12;
   localparam int CountW = 9;
   localparam int OpW    = 64;
   localparam int WideW  = 128;
   localparam int CoefW  = 48;
   localparam int NumOps = 24;
   localparam int OpIdxW = 5;

   typedef enum logic [3:0] {
      OPD_N, OPD_S1, OPD_S2, OPD_S3, OPD_S4, OPD_T0, OPD_T1, OPD_T2,
      OPD_MA, OPD_MB, OPD_MC, OPD_UA, OPD_UB, OPD_UC
   } opd_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_MA, DST_MB, DST_MC, DST_UA, DST_UB, DST_UC,
      DST_DET, DST_NUM2, DST_NUM1, DST_NUM0
   } dst_type;

   typedef struct packed {
      opd_type a;
      opd_type b;
      logic    sub;
      logic    first;
      dst_type dst;
   } mop_type;

   typedef enum logic [2:0] {
      DIV_SLOPE, DIV_ICPT, DIV_C2, DIV_C1, DIV_C0
   } dsel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PMUL1, ST_PMUL2, ST_PACC, ST_SOLVE, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic     pt_load;
      logic     pt_mul1;
      logic     pt_mul2;
      logic     pt_acc;
      logic     solve_clr;
      logic     m_load;
      logic     m_pp;
      logic     m_add;
      logic     m_fin;
      mop_type  op;
      logic     div_go;
      dsel_type dsel;
      logic     rsp_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic ma_zero;
      logic det_zero;
      logic div_done;
      logic rsp_full;
   } sts_type;

   function automatic mop_type mop(opd_type a, opd_type b, logic sub, logic first,
                                   dst_type dst);
      mop_type m;
      m.a     = a;
      m.b     = b;
      m.sub   = sub;
      m.first = first;
      m.dst   = dst;
      return m;
   endfunction

   // cramer solve as multiply-accumulate steps
   function automatic mop_type plsf_prog(logic [OpIdxW-1:0] idx);
      mop_type m;
      unique case (idx)
         5'd0:  m = mop(OPD_S2, OPD_N,  1'b0, 1'b1, DST_NONE);
         5'd1:  m = mop(OPD_S1, OPD_S1, 1'b1, 1'b0, DST_MA);
         5'd2:  m = mop(OPD_S3, OPD_N,  1'b0, 1'b1, DST_NONE);
         5'd3:  m = mop(OPD_S1, OPD_S2, 1'b1, 1'b0, DST_MB);
         5'd4:  m = mop(OPD_S3, OPD_S1, 1'b0, 1'b1, DST_NONE);
         5'd5:  m = mop(OPD_S2, OPD_S2, 1'b1, 1'b0, DST_MC);
         5'd6:  m = mop(OPD_T1, OPD_N,  1'b0, 1'b1, DST_NONE);
         5'd7:  m = mop(OPD_S1, OPD_T0, 1'b1, 1'b0, DST_UA);
         5'd8:  m = mop(OPD_T1, OPD_S1, 1'b0, 1'b1, DST_NONE);
         5'd9:  m = mop(OPD_S2, OPD_T0, 1'b1, 1'b0, DST_UB);
         5'd10: m = mop(OPD_S3, OPD_T0, 1'b0, 1'b1, DST_NONE);
         5'd11: m = mop(OPD_T1, OPD_S2, 1'b1, 1'b0, DST_UC);
         5'd12: m = mop(OPD_S4, OPD_MA, 1'b0, 1'b1, DST_NONE);
         5'd13: m = mop(OPD_S3, OPD_MB, 1'b1, 1'b0, DST_NONE);
         5'd14: m = mop(OPD_S2, OPD_MC, 1'b0, 1'b0, DST_DET);
         5'd15: m = mop(OPD_T2, OPD_MA, 1'b0, 1'b1, DST_NONE);
         5'd16: m = mop(OPD_S3, OPD_UA, 1'b1, 1'b0, DST_NONE);
         5'd17: m = mop(OPD_S2, OPD_UB, 1'b0, 1'b0, DST_NUM2);
         5'd18: m = mop(OPD_S4, OPD_UA, 1'b0, 1'b1, DST_NONE);
         5'd19: m = mop(OPD_T2, OPD_MB, 1'b1, 1'b0, DST_NONE);
         5'd20: m = mop(OPD_S2, OPD_UC, 1'b0, 1'b0, DST_NUM1);
         5'd21: m = mop(OPD_S4, OPD_UB, 1'b1, 1'b1, DST_NONE);
         5'd22: m = mop(OPD_S3, OPD_UC, 1'b1, 1'b0, DST_NONE);
         5'd23: m = mop(OPD_T2, OPD_MC, 1'b0, 1'b0, DST_NUM0);
         default: m = mop(OPD_N, OPD_N, 1'b0, 1'b1, DST_NONE);
      endcase
      return m;
   endfunction

endpackage

// ----- src/plsf_div.sv -----
// ----------------------------------------------------------------------------
// plsf_div
// bit-serial fixed-point divider with round-half-away and 48-bit saturation
// ----------------------------------------------------------------------------
module plsf_div
   import plsf_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic signed [WideW-1:0] num,
   input  logic signed [WideW-1:0] den,
   output logic                    done,
   output logic [CoefW-1:0]        quot
);

   localparam int DW   = WideW + FRAC_BITS + 1;
   localparam int CntW = $clog2(DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]     nq_ff, nq_in;
   logic [WideW-1:0]  rem_ff, rem_in;
   logic [WideW-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;

   logic [WideW:0]    remsh, diff;
   logic              ge;
   logic [WideW-1:0]  num_mag, den_mag;
   logic [DW-1:0]     q1;
   logic [DW-2:0]     qh;
   logic [CoefW-1:0]  lim, mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      num_mag = num[WideW-1] ? WideW'(-num) : WideW'(num);
      den_mag = den[WideW-1] ? WideW'(-den) : WideW'(den);
      remsh   = {rem_ff, nq_ff[DW-1]};
      diff    = remsh - {1'b0, den_ff};
      ge      = (remsh >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DW);
         nq_in   = DW'(num_mag) << (FRAC_BITS + 1);
         rem_in  = '0;
         den_in  = den_mag;
         neg_in  = num[WideW-1] ^ den[WideW-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[WideW-1:0] : remsh[WideW-1:0];
         nq_in  = {nq_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // quotient plus one half lsb, then drop the extra bit
   always_comb begin
      q1  = nq_ff + 1'b1;
      qh  = q1[DW-1:1];
      lim = neg_ff ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
      mag = (qh > (DW-1)'(lim)) ? lim : qh[CoefW-1:0];
      quot = neg_ff ? (~mag + 1'b1) : mag;
   end

   assign done = done_ff;

endmodule

// ----- src/plsf_dpath.sv -----
// ----------------------------------------------------------------------------
// plsf_dpath
// point sums, shared 32x32 multiply-accumulate, minors, divider and result register
// ----------------------------------------------------------------------------
module plsf_dpath
   import plsf_pkg::*;
#(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [23:0]   req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [255:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser
);

   // point stage
   logic signed [CoordW-1:0]   x_ff, y_ff;
   logic                       last_ff;
   logic signed [2*CoordW-1:0] xx_ff, xy_ff;
   logic signed [3*CoordW-1:0] x3_ff, x2y_ff;
   logic signed [4*CoordW-1:0] x4_ff;

   // running sums
   logic [CountW-1:0]  count_ff;
   logic signed [19:0] s1_ff, t0_ff;
   logic signed [30:0] s2_ff, t1_ff;
   logic signed [41:0] s3_ff, t2_ff;
   logic signed [52:0] s4_ff;

   // solve
   logic [OpW-1:0]           ma_abs_ff, mb_abs_ff;
   logic                     psign_ff;
   logic [1:0]               pidx_ff;
   logic [1:0]               ppsh_ff;
   logic [OpW-1:0]           pp_ff;
   logic [WideW-1:0]         prod_ff;
   logic signed [WideW-1:0]  acc_ff;
   logic signed [OpW-1:0]    ma_ff, mb_ff, mc_ff, ua_ff, ub_ff, uc_ff;
   logic signed [WideW-1:0]  det_ff, num2_ff, num1_ff, num0_ff;
   logic [CoefW-1:0]         c2_ff, c1_ff, c0_ff, slope_ff, icpt_ff;

   logic                     rsp_valid_ff;
   logic [255:0]             rsp_data_ff;
   logic [1:0]               rsp_user_ff;

   logic signed [OpW-1:0]    opa, opb;
   logic [WideW-1:0]         pp_sh;
   logic signed [WideW-1:0]  pv, sum;
   logic signed [WideW-1:0]  dnum, dden;
   logic                     div_done;
   logic [CoefW-1:0]         div_q;

   function automatic logic signed [OpW-1:0] pick(opd_type s);
      logic signed [OpW-1:0] v;
      unique case (s)
         OPD_N:   v = OpW'($signed({1'b0, count_ff}));
         OPD_S1:  v = OpW'(s1_ff);
         OPD_S2:  v = OpW'(s2_ff);
         OPD_S3:  v = OpW'(s3_ff);
         OPD_S4:  v = OpW'(s4_ff);
         OPD_T0:  v = OpW'(t0_ff);
         OPD_T1:  v = OpW'(t1_ff);
         OPD_T2:  v = OpW'(t2_ff);
         OPD_MA:  v = ma_ff;
         OPD_MB:  v = mb_ff;
         OPD_MC:  v = mc_ff;
         OPD_UA:  v = ua_ff;
         OPD_UB:  v = ub_ff;
         OPD_UC:  v = uc_ff;
         default: v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      opa = pick(cmd.op.a);
      opb = pick(cmd.op.b);
      case (ppsh_ff)
         2'd0:    pp_sh = {64'b0, pp_ff};
         2'd1:    pp_sh = {32'b0, pp_ff, 32'b0};
         default: pp_sh = {pp_ff, 64'b0};
      endcase
      pv  = psign_ff ? -$signed(prod_ff) : $signed(prod_ff);
      sum = (cmd.op.first ? '0 : acc_ff) + pv;
   end

   always_comb begin
      unique case (cmd.dsel)
         DIV_SLOPE: begin dnum = WideW'(ua_ff);  dden = WideW'(ma_ff); end
         DIV_ICPT:  begin dnum = -WideW'(ub_ff); dden = WideW'(ma_ff); end
         DIV_C2:    begin dnum = num2_ff;        dden = det_ff;        end
         DIV_C1:    begin dnum = num1_ff;        dden = det_ff;        end
         DIV_C0:    begin dnum = num0_ff;        dden = det_ff;        end
         default:   begin dnum = '0;             dden = '0;            end
      endcase
   end

   plsf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .go    (cmd.div_go),
      .num   (dnum),
      .den   (dden),
      .done  (div_done),
      .quot  (div_q)
   );

   // point products and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         s1_ff <= '0; s2_ff <= '0; s3_ff <= '0; s4_ff <= '0;
         t0_ff <= '0; t1_ff <= '0; t2_ff <= '0;
      end else if (cmd.rsp_load) begin
         count_ff <= '0;
         s1_ff <= '0; s2_ff <= '0; s3_ff <= '0; s4_ff <= '0;
         t0_ff <= '0; t1_ff <= '0; t2_ff <= '0;
      end else if (cmd.pt_acc && (count_ff < CountW'(MAX_POINTS))) begin
         count_ff <= count_ff + 1'b1;
         s1_ff <= s1_ff + 20'(x_ff);
         s2_ff <= s2_ff + 31'(xx_ff);
         s3_ff <= s3_ff + 42'(x3_ff);
         s4_ff <= s4_ff + 53'(x4_ff);
         t0_ff <= t0_ff + 20'(y_ff);
         t1_ff <= t1_ff + 31'(xy_ff);
         t2_ff <= t2_ff + 42'(x2y_ff);
      end
      if (cmd.pt_load) begin
         x_ff    <= CoordW'($signed(req_tdata[COORD_BITS-1:0]));
         y_ff    <= CoordW'($signed(req_tdata[CoordW+COORD_BITS-1:CoordW]));
         last_ff <= req_tlast;
      end
      if (cmd.pt_mul1) begin
         xx_ff <= x_ff * x_ff;
         xy_ff <= x_ff * y_ff;
      end
      if (cmd.pt_mul2) begin
         x3_ff  <= xx_ff * x_ff;
         x4_ff  <= xx_ff * xx_ff;
         x2y_ff <= xx_ff * y_ff;
      end
   end

   // multiply-accumulate over four 32x32 partial products
   always_ff @(posedge clock) begin
      if (cmd.m_load) begin
         ma_abs_ff <= opa[OpW-1] ? OpW'(-opa) : OpW'(opa);
         mb_abs_ff <= opb[OpW-1] ? OpW'(-opb) : OpW'(opb);
         psign_ff  <= opa[OpW-1] ^ opb[OpW-1] ^ cmd.op.sub;
         pidx_ff   <= '0;
         prod_ff   <= '0;
      end else begin
         if (cmd.m_pp) begin
            pp_ff   <= OpW'(pidx_ff[1] ? ma_abs_ff[63:32] : ma_abs_ff[31:0])
                       * OpW'(pidx_ff[0] ? mb_abs_ff[63:32] : mb_abs_ff[31:0]);
            ppsh_ff <= {1'b0, pidx_ff[1]} + {1'b0, pidx_ff[0]};
            pidx_ff <= pidx_ff + 1'b1;
         end
         if (cmd.m_add) begin
            prod_ff <= prod_ff + pp_sh;
         end
      end
      if (cmd.m_fin) begin
         acc_ff <= sum;
         case (cmd.op.dst)
            DST_MA:   ma_ff   <= sum[OpW-1:0];
            DST_MB:   mb_ff   <= sum[OpW-1:0];
            DST_MC:   mc_ff   <= sum[OpW-1:0];
            DST_UA:   ua_ff   <= sum[OpW-1:0];
            DST_UB:   ub_ff   <= sum[OpW-1:0];
            DST_UC:   uc_ff   <= sum[OpW-1:0];
            DST_DET:  det_ff  <= sum;
            DST_NUM2: num2_ff <= sum;
            DST_NUM1: num1_ff <= sum;
            DST_NUM0: num0_ff <= sum;
            default:  ;
         endcase
      end
   end

   // coefficients, zero unless a division writes them
   always_ff @(posedge clock) begin
      if (cmd.solve_clr) begin
         c2_ff <= '0; c1_ff <= '0; c0_ff <= '0; slope_ff <= '0; icpt_ff <= '0;
      end else if (div_done) begin
         case (cmd.dsel)
            DIV_SLOPE: slope_ff <= div_q;
            DIV_ICPT:  icpt_ff  <= div_q;
            DIV_C2:    c2_ff    <= div_q;
            DIV_C1:    c1_ff    <= div_q;
            DIV_C0:    c0_ff    <= div_q;
            default:   ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {7'b0, count_ff, icpt_ff, slope_ff, c0_ff, c1_ff, c2_ff};
         rsp_user_ff <= {det_ff == '0, ma_ff == '0};
      end
   end

   assign sts.last     = last_ff;
   assign sts.ma_zero  = (ma_ff == '0);
   assign sts.det_zero = (det_ff == '0);
   assign sts.div_done = div_done;
   assign sts.rsp_full = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- src/plsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// plsf_ctrl
// sequencer for point intake, the multiply-accumulate solve and the divisions
// ----------------------------------------------------------------------------
`include "poly_least_squares_fit_core_assert.svh"

module plsf_ctrl
   import plsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type          state_ff, state_in;
   logic [OpIdxW-1:0]  op_ff, op_in;
   logic [2:0]         step_ff, step_in;
   dsel_type           dsel_ff, dsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= '0;
         step_ff  <= '0;
         dsel_ff  <= DIV_SLOPE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         step_ff  <= step_in;
         dsel_ff  <= dsel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      step_in    = step_ff;
      dsel_in    = dsel_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.op     = plsf_prog(op_ff);
      cmd.dsel   = dsel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.pt_load = 1'b1;
               state_in    = ST_PMUL1;
            end
         end
         ST_PMUL1: begin
            cmd.pt_mul1 = 1'b1;
            state_in    = ST_PMUL2;
         end
         ST_PMUL2: begin
            cmd.pt_mul2 = 1'b1;
            state_in    = ST_PACC;
         end
         ST_PACC: begin
            cmd.pt_acc = 1'b1;
            if (sts.last) begin
               cmd.solve_clr = 1'b1;
               op_in         = '0;
               step_in       = '0;
               state_in      = ST_SOLVE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SOLVE: begin
            // step 0 loads operands, 1..4 multiply, 2..5 sum, 6 accumulates
            cmd.m_load = (step_ff == 3'd0);
            cmd.m_pp   = (step_ff >= 3'd1) && (step_ff <= 3'd4);
            cmd.m_add  = (step_ff >= 3'd2) && (step_ff <= 3'd5);
            cmd.m_fin  = (step_ff == 3'd6);
            if (step_ff == 3'd6) begin
               step_in = '0;
               if (op_ff == OpIdxW'(NumOps - 1)) begin
                  if (!sts.ma_zero) begin
                     dsel_in  = DIV_SLOPE;
                     state_in = ST_DIV_GO;
                  end else if (!sts.det_zero) begin
                     dsel_in  = DIV_C2;
                     state_in = ST_DIV_GO;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  op_in = op_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_DIV_GO;
               unique case (dsel_ff)
                  DIV_SLOPE: dsel_in = DIV_ICPT;
                  DIV_ICPT: begin
                     if (!sts.det_zero) begin
                        dsel_in = DIV_C2;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  DIV_C2:  dsel_in = DIV_C1;
                  DIV_C1:  dsel_in = DIV_C0;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `PLSF_IMPLY(a_rsp_free, cmd.rsp_load, !sts.rsp_full, "result loaded over a stalled result")
   `PLSF_IMPLY(a_line_div, cmd.div_go && (cmd.dsel == DIV_SLOPE || cmd.dsel == DIV_ICPT), !sts.ma_zero, "line division with zero denominator")
   `PLSF_IMPLY(a_quad_div, cmd.div_go && (cmd.dsel == DIV_C2 || cmd.dsel == DIV_C1 || cmd.dsel == DIV_C0), !sts.det_zero, "quadratic division with zero determinant")
   `PLSF_NEXT(a_step_wrap, state_ff == ST_SOLVE && step_ff == 3'd6, step_ff == 3'd0, "solve step counter did not wrap")

endmodule

// ----- src/poly_least_squares_fit_core.sv -----
// ----------------------------------------------------------------------------
// poly_least_squares_fit_core
// quadratic and straight-line least-squares fit over a stream of sample points
// ----------------------------------------------------------------------------
// Sample points enter on the req_ channel, one per request; req_tlast marks the
// final point of a set. Each point runs through accept, two multiply stages
// and a sum update. Points beyond MAX_POINTS are not summed. The final point
// starts a solve: 24 multiply-accumulate steps, each run on one shared 32x32
// multiplier, then up to five bit-serial divisions. The result then lands in
// an output register on the rsp_ channel. req_tready is high while no point
// or solve is in progress; a result waiting on a stalled rsp_tready does not
// hold off new points, but the result of the next solve waits until the
// register is free. Synchronous reset clears all sums, the point count and
// the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module poly_least_squares_fit_core
   import plsf_pkg::*;
#(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // point_x[11:0], point_y[23:12]
   input  logic         req_tlast,   // last_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata,   // quad_c2, quad_c1, quad_c0, line_slope,
                                     // line_intercept (48 each), point_count[248:240]
   output logic [1:0]   rsp_tuser    // line_singular, quad_singular
);

   cmd_type cmd;
   sts_type sts;

   plsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   plsf_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/tb_poly_least_squares_fit_core.sv -----
// ----------------------------------------------------------------------------
// tb_poly_least_squares_fit_core
// self-checking bench for the quadratic and straight-line least-squares fitter
// ----------------------------------------------------------------------------
// Points are streamed in sets closed by req_tlast. A predictor keeps the exact
// sums on 64-bit integers, solves by Cramer's rule in 256 bits at each last
// point and queues the expected fit. The directed rows come first, then random
// sets of mixed sizes and shapes. Both sides idle at random, and once the
// receiver stalls for a long stretch so that the core backs up onto its input.
// ----------------------------------------------------------------------------
module tb_poly_least_squares_fit_core;
   import plsf_pkg::*;

   localparam int MaxPoints  = 256;
   localparam int FracBits   = 24;
   localparam int IdleLimit  = 20000;
   localparam int DrainWait  = 1000;
   localparam int StallLen   = 3000;
   localparam int NumItems   = 1500;

   typedef logic signed [255:0] wide_t;

   typedef struct packed {
      logic [47:0] c2;
      logic [47:0] c1;
      logic [47:0] c0;
      logic [47:0] slope;
      logic [47:0] icpt;
      logic        line_sing;
      logic        quad_sing;
      logic [8:0]  count;
   } fit_t;

   typedef struct {
      int   x;
      int   y;
      bit   last;
      bit   known;
      fit_t fit;
   } row_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   poly_least_squares_fit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // running sums of the current set
   int     pts_held;
   longint sum_x, sum_x2, sum_x3, sum_x4, sum_y, sum_xy, sum_x2y;

   fit_t   fit_q[$];
   int     err_count;
   int     fits_seen;
   int     idle_cycles;
   int     rx_wait;
   bit     rx_burst;
   bit     tx_burst;
   row_t   rows[$];

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h (fit %0d)", what, got, want, fits_seen);
      err_count++;
   endtask

   function automatic wide_t det2(wide_t a, wide_t b, wide_t c, wide_t d);
      return a * b - c * d;
   endfunction

   // round(num * 2^frac / den), ties away from zero, clamped to 48 bits
   function automatic logic [47:0] fix_quot(wide_t num, wide_t den);
      logic        neg;
      logic [255:0] nu, du, q, lim, mag;
      neg = num[255] ^ den[255];
      nu  = num[255] ? -num : num;
      du  = den[255] ? -den : den;
      q   = ((nu << (FracBits + 1)) / du + 256'd1) >> 1;
      lim = neg ? (256'd1 << 47) : ((256'd1 << 47) - 256'd1);
      mag = (q > lim) ? lim : q;
      return neg ? -mag[47:0] : mag[47:0];
   endfunction

   function automatic fit_t solve_sums();
      wide_t n, s1, s2, s3, s4, t0, t1, t2, dl, det;
      wide_t ma, mb, mc, ua, ub, uc;
      fit_t  f;
      n  = wide_t'(longint'(pts_held));
      s1 = sum_x;  s2 = sum_x2; s3 = sum_x3; s4 = sum_x4;
      t0 = sum_y;  t1 = sum_xy; t2 = sum_x2y;
      f  = '0;
      dl = det2(n, s2, s1, s1);
      if (dl == 0) begin
         f.line_sing = 1'b1;
      end else begin
         f.slope = fix_quot(det2(n, t1, s1, t0), dl);
         f.icpt  = fix_quot(det2(t0, s2, t1, s1), dl);
      end
      ma  = det2(s2, n, s1, s1);
      mb  = det2(s3, n, s1, s2);
      mc  = det2(s3, s1, s2, s2);
      det = s4 * ma - s3 * mb + s2 * mc;
      if (det == 0) begin
         f.quad_sing = 1'b1;
      end else begin
         ua   = det2(t1, n, s1, t0);
         ub   = det2(t1, s1, s2, t0);
         uc   = det2(s3, t0, t1, s2);
         f.c2 = fix_quot(t2 * ma - s3 * ua + s2 * ub, det);
         f.c1 = fix_quot(s4 * ua - t2 * mb + s2 * uc, det);
         f.c0 = fix_quot(s4 * (-ub) - s3 * uc + t2 * mc, det);
      end
      f.count = pts_held[8:0];
      return f;
   endfunction

   // fold one accepted point into the sums; returns 1 when a fit is due
   function automatic bit add_point(int x, int y, bit last, output fit_t f);
      longint xl, yl, xx;
      xl = x;
      yl = y;
      xx = xl * xl;
      f  = '0;
      if (pts_held < MaxPoints) begin
         pts_held++;
         sum_x  += xl;      sum_x2 += xx;      sum_x3  += xx * xl;
         sum_x4 += xx * xx; sum_y  += yl;      sum_xy  += xl * yl;
         sum_x2y += xx * yl;
      end
      if (!last) return 1'b0;
      f = solve_sums();
      pts_held = 0;
      sum_x = 0; sum_x2 = 0; sum_x3 = 0; sum_x4 = 0;
      sum_y = 0; sum_xy = 0; sum_x2y = 0;
      return 1'b1;
   endfunction

   // called at a falling edge, returns at a falling edge after acceptance
   task automatic send_point(int x, int y, bit last, bit known, fit_t typed);
      int   gap;
      fit_t f;
      gap = tx_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y[11:0], x[11:0]};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (add_point(x, y, last, f)) fit_q.push_back(known ? typed : f);
      @(negedge clock);
   endtask

   function automatic row_t mkrow(int x, int y, bit last, bit known = 0, fit_t f = '0);
      row_t r;
      r.x = x; r.y = y; r.last = last; r.known = known; r.fit = f;
      return r;
   endfunction

   function automatic fit_t typed_fit(logic [47:0] slope, logic ls, logic qs,
                                      logic [8:0] cnt);
      fit_t f;
      f = '0;
      f.slope = slope; f.line_sing = ls; f.quad_sing = qs; f.count = cnt;
      return f;
   endfunction

   // result side: check against the oldest expected fit
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         fit_t want;
         if (fit_q.size() == 0) begin
            $display("unexpected fit response: %h", rsp_tdata);
            err_count++;
         end else begin
            want = fit_q.pop_front();
            if (rsp_tdata[47:0] !== want.c2)       report("quad_c2", rsp_tdata[47:0], want.c2);
            if (rsp_tdata[95:48] !== want.c1)      report("quad_c1", rsp_tdata[95:48], want.c1);
            if (rsp_tdata[143:96] !== want.c0)     report("quad_c0", rsp_tdata[143:96], want.c0);
            if (rsp_tdata[191:144] !== want.slope)
               report("line_slope", rsp_tdata[191:144], want.slope);
            if (rsp_tdata[239:192] !== want.icpt)
               report("line_intercept", rsp_tdata[239:192], want.icpt);
            if (rsp_tuser[0] !== want.line_sing)
               report("line_singular", rsp_tuser[0], want.line_sing);
            if (rsp_tuser[1] !== want.quad_sing)
               report("quad_singular", rsp_tuser[1], want.quad_sing);
            if (rsp_tdata[248:240] !== want.count)
               report("point_count", rsp_tdata[248:240], want.count);
         end
         fits_seen++;
         if ($urandom_range(0, 7) == 0) rx_burst = ~rx_burst;
         if (fits_seen == 12) rx_wait = StallLen;
         else rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
      end
   end

   always @(negedge clock) begin
      if (rx_wait > 0) begin
         rsp_tready <= 1'b0;
         rx_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int sent, sz, kind, lo, hi, x, y, a, b;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      pts_held   = 0;
      sum_x = 0; sum_x2 = 0; sum_x3 = 0; sum_x4 = 0;
      sum_y = 0; sum_xy = 0; sum_x2y = 0;
      err_count = 0; fits_seen = 0; idle_cycles = 0; rx_wait = 0;
      rx_burst = 0; tx_burst = 0;

      // single point: both fits singular
      rows.push_back(mkrow(5, -7, 1, 1, typed_fit('0, 1, 1, 9'd1)));
      // two points on one x: both singular
      rows.push_back(mkrow(-2048, 2047, 0));
      rows.push_back(mkrow(-2048, -2048, 1, 1, typed_fit('0, 1, 1, 9'd2)));
      // two distinct x on y = x: slope one, quadratic singular
      rows.push_back(mkrow(0, 0, 0));
      rows.push_back(mkrow(1, 1, 1, 1, typed_fit(48'd1 << FracBits, 0, 1, 9'd2)));
      // exact parabola
      rows.push_back(mkrow(0, 0, 0));
      rows.push_back(mkrow(1, 1, 0));
      rows.push_back(mkrow(-1, 1, 1));
      // coordinate extremes
      rows.push_back(mkrow(-2048, -2048, 0));
      rows.push_back(mkrow(2047, 2047, 0));
      rows.push_back(mkrow(0, -2048, 0));
      rows.push_back(mkrow(-2048, 2047, 0));
      rows.push_back(mkrow(2047, -2048, 1));
      // steep near-degenerate set for saturation
      rows.push_back(mkrow(2046, -2048, 0));
      rows.push_back(mkrow(2047, 2047, 0));
      rows.push_back(mkrow(-2048, 0, 0));
      rows.push_back(mkrow(-2048, 0, 1));
      // many points on one x: line singular
      rows.push_back(mkrow(3, 100, 0));
      rows.push_back(mkrow(3, -100, 0));
      rows.push_back(mkrow(3, 0, 1));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].known,
                                   rows[i].fit);

      sent = 0;
      while (sent < NumItems) begin
         kind     = $urandom_range(0, 9);
         tx_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 59) == 0) sz = $urandom_range(257, 300);
         else if (kind == 9) sz = $urandom_range(1, 2);
         else sz = $urandom_range(3, 12);
         lo = -2048; hi = 2047;
         if (kind >= 6 && kind <= 8) begin
            lo = -3; hi = 3;
         end
         a = $urandom_range(0, 8) - 4;
         b = $urandom_range(0, 400) - 200;
         for (int k = 0; k < sz; k++) begin
            x = $urandom_range(0, hi - lo) + lo;
            // noisy line, kept in signed arithmetic
            if (kind == 5) y = a * x / 4 + b + int'($urandom_range(0, 2)) - 1;
            else y = $urandom_range(0, 4095) - 2048;
            if (y > 2047) y = 2047;
            if (y < -2048) y = -2048;
            send_point(x, y, k == sz - 1, 0, '0);
            sent++;
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (fit_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
